// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every check is sampled on the rising edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This check holds in every cycle.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// This check holds in the cycle after its precondition.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, constants and arithmetic helpers for the Euler-to-quaternion block.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN          = 24;
  localparam int STAGES = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
  localparam int IDX_W             = $clog2(ATAN_LEN);

  localparam int ANGLE_W   = 16;
  localparam int COMP_W    = 16;
  localparam int CW        = 34;          // CORDIC datapath, signed Q.30 plus headroom
  localparam int CS_SHIFT  = 14;          // Q.30 down to Q.16
  localparam int CS_W      = 18;          // cosine and sine, signed Q.16
  localparam int P2_W      = 2 * CS_W;
  localparam int P3_W      = 3 * CS_W;
  localparam int SUM_W     = P3_W + 2;
  localparam int RND_SHIFT = 34;          // Q.48 down to Q.14
  localparam int RES_W     = SUM_W - RND_SHIFT;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = ANGLE_W'(25736);
  localparam logic signed [CW-1:0]      CORDIC_GAIN = CW'(652032874);
  localparam logic signed [CW-1:0]      CS_HALF     = CW'(1 << (CS_SHIFT - 1));
  localparam logic signed [SUM_W-1:0]   RND_HALF    = SUM_W'(64'sd1 <<< (RND_SHIFT - 1));
  localparam logic signed [RES_W-1:0]   COMP_MAX    = RES_W'(16384);

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] q_w;
    logic signed [COMP_W-1:0] q_x;
    logic signed [COMP_W-1:0] q_y;
    logic signed [COMP_W-1:0] q_z;
  } quat_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } cordic_t;

  // Arctangent of 2^-i in Q.30, rounded down.
  function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:    r = CW'(843314856);
      5'd1:    r = CW'(497837829);
      5'd2:    r = CW'(263043836);
      5'd3:    r = CW'(133525158);
      5'd4:    r = CW'(67021686);
      5'd5:    r = CW'(33543515);
      5'd6:    r = CW'(16775850);
      5'd7:    r = CW'(8388437);
      5'd8:    r = CW'(4194282);
      5'd9:    r = CW'(2097149);
      5'd10:   r = CW'(1048575);
      5'd11:   r = CW'(524287);
      5'd12:   r = CW'(262143);
      5'd13:   r = CW'(131071);
      5'd14:   r = CW'(65535);
      5'd15:   r = CW'(32767);
      5'd16:   r = CW'(16383);
      5'd17:   r = CW'(8191);
      5'd18:   r = CW'(4095);
      5'd19:   r = CW'(2047);
      5'd20:   r = CW'(1023);
      5'd21:   r = CW'(511);
      5'd22:   r = CW'(255);
      5'd23:   r = CW'(127);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Start vector for one angle: saturate to pi, then Q3.13 halved becomes Q.30.
  function automatic lane_t lane_init(input logic signed [ANGLE_W-1:0] a);
    logic signed [ANGLE_W-1:0] sat;
    lane_t r;
    sat = a;
    if (a > ANGLE_LIMIT) begin
      sat = ANGLE_LIMIT;
    end else if (a < -ANGLE_LIMIT) begin
      sat = -ANGLE_LIMIT;
    end
    r.x = CORDIC_GAIN;
    r.y = '0;
    r.z = CW'(sat) <<< 16;
    return r;
  endfunction

  // One rotation-mode step; the shifts round toward minus infinity.
  function automatic lane_t cordic_step(input lane_t l, input logic [IDX_W-1:0] i);
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] da;
    lane_t r;
    x  = l.x;
    y  = l.y;
    z  = l.z;
    da = atan_q30(i);
    if (!z[CW-1]) begin
      r.x = x - (y >>> i);
      r.y = y + (x >>> i);
      r.z = z - da;
    end else begin
      r.x = x + (y >>> i);
      r.y = y - (x >>> i);
      r.z = z + da;
    end
    return r;
  endfunction

  function automatic logic signed [CS_W-1:0] round_cs(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = v + CS_HALF;
    return CS_W'(t >>> CS_SHIFT);
  endfunction

  function automatic logic signed [COMP_W-1:0] to_comp(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    logic signed [RES_W-1:0] r;
    t = (v + RND_HALF) >>> RND_SHIFT;
    r = RES_W'(t);
    if (r > COMP_MAX) begin
      r = COMP_MAX;
    end else if (r < -COMP_MAX) begin
      r = -COMP_MAX;
    end
    return COMP_W'(r);
  endfunction

endpackage

// ===== rtl/e2q_cell.sv =====
// ----------------------------------------------------------------------------
// e2q_cell
// One CORDIC iteration for the roll, pitch and yaw lanes, with its own register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module e2q_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [e2q_pkg::IDX_W-1:0] stage,
  input  logic                      up_valid,
  input  e2q_pkg::cordic_t          up_beat,
  output logic                      up_stall,
  output logic                      valid,
  output e2q_pkg::cordic_t          beat,
  input  logic                      down_stall
);
  import e2q_pkg::*;

  logic    advance;
  cordic_t beat_next;

  // The register moves when it is empty or its beat leaves downstream.
  assign advance  = !valid || !down_stall;
  assign up_stall = !advance;

  always_comb begin
    beat_next.roll  = cordic_step(up_beat.roll, stage);
    beat_next.pitch = cordic_step(up_beat.pitch, stage);
    beat_next.yaw   = cordic_step(up_beat.yaw, stage);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      beat <= beat_next;
    end
  end

  `ASSERT_NEXT(a_cell_hold, valid && down_stall, valid && $stable(beat), "cell lost a held beat")

endmodule

// ===== rtl/e2q_mix.sv =====
// ----------------------------------------------------------------------------
// e2q_mix
// Rounds cosine and sine, forms the three-factor products and the quaternion.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module e2q_mix (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  e2q_pkg::cordic_t up_beat,
  output logic             up_stall,
  output logic             valid,
  output e2q_pkg::quat_t   quat,
  input  logic             down_stall
);
  import e2q_pkg::*;

  logic valid_a;
  logic valid_b;
  logic adv_a;
  logic adv_b;
  logic adv_c;

  logic signed [CS_W-1:0] cr, sr, cp, sp, cy_next, sy_next;
  logic signed [CS_W-1:0] cy, sy;
  logic signed [P2_W-1:0] cc, ss, sc, csp;
  logic signed [P3_W-1:0] w1, w2, x1, x2, y1, y2, z1, z2;
  quat_t                  quat_next;

  assign adv_c    = !valid || !down_stall;
  assign adv_b    = !valid_b || adv_c;
  assign adv_a    = !valid_a || adv_b;
  assign up_stall = !adv_a;

  always_comb begin
    cr      = round_cs(up_beat.roll.x);
    sr      = round_cs(up_beat.roll.y);
    cp      = round_cs(up_beat.pitch.x);
    sp      = round_cs(up_beat.pitch.y);
    cy_next = round_cs(up_beat.yaw.x);
    sy_next = round_cs(up_beat.yaw.y);
  end

  always_comb begin
    quat_next.q_w = to_comp(SUM_W'(w1) + SUM_W'(w2));
    quat_next.q_x = to_comp(SUM_W'(x1) - SUM_W'(x2));
    quat_next.q_y = to_comp(SUM_W'(y1) + SUM_W'(y2));
    quat_next.q_z = to_comp(SUM_W'(z1) - SUM_W'(z2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid   <= 1'b0;
    end else begin
      if (adv_a) begin
        valid_a <= up_valid;
      end
      if (adv_b) begin
        valid_b <= valid_a;
      end
      if (adv_c) begin
        valid <= valid_b;
      end
    end
  end

  // Roll and pitch pairs first, then each pair times the yaw term.
  always_ff @(posedge clk) begin
    if (adv_a && up_valid) begin
      cc  <= P2_W'(cr) * P2_W'(cp);
      ss  <= P2_W'(sr) * P2_W'(sp);
      sc  <= P2_W'(sr) * P2_W'(cp);
      csp <= P2_W'(cr) * P2_W'(sp);
      cy  <= cy_next;
      sy  <= sy_next;
    end
    if (adv_b && valid_a) begin
      w1 <= P3_W'(cc) * P3_W'(cy);
      w2 <= P3_W'(ss) * P3_W'(sy);
      x1 <= P3_W'(sc) * P3_W'(cy);
      x2 <= P3_W'(csp) * P3_W'(sy);
      y1 <= P3_W'(csp) * P3_W'(cy);
      y2 <= P3_W'(sc) * P3_W'(sy);
      z1 <= P3_W'(cc) * P3_W'(sy);
      z2 <= P3_W'(ss) * P3_W'(cy);
    end
    if (adv_c && valid_b) begin
      quat <= quat_next;
    end
  end

  `ASSERT_NEXT(a_mix_fill, valid_b && adv_c, valid, "product beat did not reach the output")
  `ASSERT_ALWAYS(a_mix_range, !valid || (quat.q_w <= 16384 && quat.q_w >= -16384 && quat.q_x <= 16384 && quat.q_x >= -16384), "component out of range")

endmodule

// ===== rtl/euler_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll, pitch and yaw in radians to a unit quaternion, ZYX order, fixed point.
// ----------------------------------------------------------------------------
//   channel   direction  payload                         handshake
//   angles    in         angles_t (Q3.13 radians)        angles_valid / angles_stall
//   quat      out        quat_t (Q1.14 components)       quat_valid / quat_stall
//
// One beat is accepted per cycle while no stall reaches the input; a result passes
// through the row of STAGES CORDIC cells and the three product and rounding
// registers behind it.
// Reset clears only the valid bits of every stage; the data registers are not reset.
// A stall on the output holds the last register, and the stages behind it keep
// filling their empty slots before the stall reaches the input.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
  input  logic             clk,
  input  logic             rst,
  input  logic             angles_valid,
  input  e2q_pkg::angles_t angles,
  output logic             angles_stall,
  output logic             quat_valid,
  output e2q_pkg::quat_t   quat,
  input  logic             quat_stall
);
  import e2q_pkg::*;

  logic [STAGES:0] chain_valid;
  logic [STAGES:0] chain_stall;
  cordic_t         chain_beat [STAGES+1];

  assign chain_valid[0] = angles_valid;
  assign angles_stall   = chain_stall[0];

  assign chain_beat[0] = {lane_init(angles.roll_angle),
                          lane_init(angles.pitch_angle),
                          lane_init(angles.yaw_angle)};

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    e2q_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .stage      (IDX_W'(g)),
      .up_valid   (chain_valid[g]),
      .up_beat    (chain_beat[g]),
      .up_stall   (chain_stall[g]),
      .valid      (chain_valid[g+1]),
      .beat       (chain_beat[g+1]),
      .down_stall (chain_stall[g+1])
    );
  end

  e2q_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (chain_valid[STAGES]),
    .up_beat    (chain_beat[STAGES]),
    .up_stall   (chain_stall[STAGES]),
    .valid      (quat_valid),
    .quat       (quat),
    .down_stall (quat_stall)
  );

endmodule
